FILE: rtl/core/md5_pkg.sv
`default_nettype none

package md5_pkg;

    // One message word as it arrives on the request channel.
    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } md5_in_t;

    // One word of the finished digest.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  digest_index;
        logic        digest_last;
    } md5_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } md5_state_t;

    // Source of the word written into the block buffer.
    typedef enum logic [2:0] {
        SRC_WORD,
        SRC_FIRST,
        SRC_PAD80,
        SRC_ZERO,
        SRC_LEN_LO,
        SRC_LEN_HI
    } md5_src_t;

    typedef struct packed {
        logic       msg_ready;
        logic       push_en;
        md5_src_t   push_src;
        logic       load_work;
        logic       round_en;
        logic       final_en;
        logic       out_valid;
        logic       reinit;
        logic [5:0] round_idx;
        logic [3:0] fill;
        logic [1:0] out_idx;
    } md5_ctrl_t;

    localparam logic [3:0]  MD5_LAST_SLOT  = 4'd15;
    localparam logic [3:0]  MD5_LEN_SLOT   = 4'd14;
    localparam logic [5:0]  MD5_LAST_ROUND = 6'd63;
    localparam logic [1:0]  MD5_LAST_IDX   = 2'd3;
    localparam logic [31:0] MD5_PAD_WORD   = 32'h0000_0080;

    // Round phases select the boolean function.
    localparam logic [1:0]  MD5_PH_F = 2'd0;
    localparam logic [1:0]  MD5_PH_G = 2'd1;
    localparam logic [1:0]  MD5_PH_H = 2'd2;

    localparam logic [31:0] MD5_IV [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amounts, indexed by {phase, round[1:0]}.
    localparam logic [4:0] MD5_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

endpackage

`default_nettype wire

FILE: rtl/core/md5_hash_engine.sv
`default_nettype none

// Channel  | Signals                        | Direction | Moves
// ---------+--------------------------------+-----------+----------------------------------
// msg      | msg_valid, msg_ready, msg      | in        | one message word per request
// dig      | dig_valid, dig_ready, dig      | out       | one digest word per request
//
// A message word is taken while the engine is idle. The sixteenth word of a block starts
// the compression: the shared round unit runs every round on the working words, which are
// then folded into the chaining words; no word is taken until the block is through. A last
// word adds one padding write per remaining buffer slot, one or two compressions and the
// four digest words. Reset loads the initial chaining values at once.
// The digest words are held while dig_ready is low, and no request is taken meanwhile.

module md5_hash_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               msg_valid,
    output logic               msg_ready,
    input  md5_pkg::md5_in_t   msg,
    output logic               dig_valid,
    input  logic               dig_ready,
    output md5_pkg::md5_out_t  dig
);
    import md5_pkg::*;

    md5_ctrl_t   ctl;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] blk_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [31:0] a_rnd, b_rnd, c_rnd, d_rnd;
    logic [60:0] bytes_reg, bytes_next;
    logic [31:0] push_word;
    logic [2:0]  last_bytes;
    logic        accept;

    // Message word used by a round: the schedule differs in each of the four phases.
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] r;
        logic [3:0] g;
        begin
            r = rnd[3:0];
            case (rnd[5:4])
                MD5_PH_F: g = r;
                MD5_PH_G: g = r + (r << 2) + 4'd1;
                MD5_PH_H: g = r + (r << 1) + 4'd5;
                default:  g = (r << 3) - r;
            endcase
            return g;
        end
    endfunction

    // A partial last word keeps its valid bytes and carries the 0x80 marker after them; a full word is kept as it is.
    function automatic logic [31:0] first_pad_word(input logic [31:0] w,
                                                   input logic [2:0]  cnt);
        logic [31:0] r;
        begin
            case (cnt)
                3'd0:    r = MD5_PAD_WORD;
                3'd1:    r = {16'h0000, 8'h80, w[7:0]};
                3'd2:    r = {8'h00, 8'h80, w[15:0]};
                3'd3:    r = {8'h80, w[23:0]};
                default: r = w;
            endcase
            return r;
        end
    endfunction

    md5_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_valid  (msg_valid),
        .last_word  (msg.last_word),
        .count_full (msg.byte_count[2]),
        .dig_ready  (dig_ready),
        .ctl        (ctl)
    );

    md5_round u_round (
        .a     (a_reg),
        .b     (b_reg),
        .c     (c_reg),
        .d     (d_reg),
        .m     (blk_reg[msg_index(ctl.round_idx)]),
        .rnd   (ctl.round_idx),
        .a_out (a_rnd),
        .b_out (b_rnd),
        .c_out (c_rnd),
        .d_out (d_rnd)
    );

    assign msg_ready = ctl.msg_ready;
    assign accept    = ctl.msg_ready && msg_valid;

    // Counts of five to seven on a last word count as a full word.
    assign last_bytes = msg.byte_count[2] ? 3'd4 : msg.byte_count;

    always_comb
    begin
        case (ctl.push_src)
            SRC_WORD:   push_word = msg.data_word;
            SRC_FIRST:  push_word = first_pad_word(msg.data_word, last_bytes);
            SRC_PAD80:  push_word = MD5_PAD_WORD;
            SRC_LEN_LO: push_word = {bytes_reg[28:0], 3'b000};
            SRC_LEN_HI: push_word = bytes_reg[60:29];
            default:    push_word = '0;
        endcase
    end

    always_comb
    begin
        bytes_next = bytes_reg;
        if (accept)
            bytes_next = bytes_reg + (msg.last_word ? {58'd0, last_bytes} : 61'd4);
        if (ctl.reinit)
            bytes_next = '0;
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            chain_next[i] = chain_reg[i];
            if (ctl.reinit)
                chain_next[i] = MD5_IV[i];
        end
        if (ctl.final_en)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
        end
    end

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        if (ctl.load_work)
        begin
            a_next = chain_reg[0];
            b_next = chain_reg[1];
            c_next = chain_reg[2];
            d_next = chain_reg[3];
        end
        else if (ctl.round_en)
        begin
            a_next = a_rnd;
            b_next = b_rnd;
            c_next = c_rnd;
            d_next = d_rnd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg <= '0;
            for (int i = 0; i < 4; i++)
                chain_reg[i] <= MD5_IV[i];
        end
        else
        begin
            bytes_reg <= bytes_next;
            for (int i = 0; i < 4; i++)
                chain_reg[i] <= chain_next[i];
        end
    end

    // Block buffer and working words are always written before they are read.
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        if (ctl.push_en)
            blk_reg[ctl.fill] <= push_word;
    end

    assign dig_valid        = ctl.out_valid;
    assign dig.digest_word  = chain_reg[ctl.out_idx];
    assign dig.digest_index = ctl.out_idx;
    assign dig.digest_last  = (ctl.out_idx == MD5_LAST_IDX);

endmodule

`default_nettype wire

FILE: rtl/core/md5_round.sv
`default_nettype none

module md5_round (
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] m,
    input  logic [5:0]  rnd,
    output logic [31:0] a_out,
    output logic [31:0] b_out,
    output logic [31:0] c_out,
    output logic [31:0] d_out
);
    import md5_pkg::*;

    logic [31:0] f;
    logic [31:0] sum;
    logic [4:0]  s;
    logic [63:0] rot_w;

    always_comb
    begin
        case (rnd[5:4])
            MD5_PH_F: f = (b & c) | (~b & d);
            MD5_PH_G: f = (b & d) | (c & ~d);
            MD5_PH_H: f = b ^ c ^ d;
            default:  f = c ^ (b | ~d);
        endcase
    end

    assign sum   = f + a + MD5_K[rnd] + m;
    assign s     = MD5_S[{rnd[5:4], rnd[1:0]}];
    // The upper half of the doubled word shifted left is the left rotation.
    assign rot_w = {sum, sum} << s;

    assign a_out = d;
    assign d_out = c;
    assign c_out = b;
    assign b_out = b + rot_w[63:32];

endmodule

`default_nettype wire

FILE: rtl/core/md5_ctrl.sv
`default_nettype none

module md5_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               msg_valid,
    input  logic               last_word,
    input  logic               count_full,
    input  logic               dig_ready,
    output md5_pkg::md5_ctrl_t ctl
);
    import md5_pkg::*;

    md5_state_t state_reg, state_next;
    logic [5:0] round_reg, round_next;
    logic [3:0] fill_reg, fill_next;
    logic [1:0] out_idx_reg, out_idx_next;
    logic       pend80_reg, pend80_next;
    logic       lo_done_reg, lo_done_next;
    logic       len_done_reg, len_done_next;
    logic       padding_reg, padding_next;
    logic       accept;
    logic       fill_top;
    md5_src_t   pad_src;

    assign accept   = (state_reg == ST_IDLE) && msg_valid;
    assign fill_top = (fill_reg == MD5_LAST_SLOT);

    // Padding order: a pending 0x80 word, zeros up to the length slot, then the length.
    always_comb
    begin
        if (pend80_reg)
            pad_src = SRC_PAD80;
        else if (lo_done_reg)
            pad_src = SRC_LEN_HI;
        else if (fill_reg == MD5_LEN_SLOT)
            pad_src = SRC_LEN_LO;
        else
            pad_src = SRC_ZERO;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (fill_top)
                        state_next = ST_ROUND;
                    else if (last_word)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (fill_top)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == MD5_LAST_ROUND)
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                if (!padding_reg)
                    state_next = ST_IDLE;
                else if (len_done_reg)
                    state_next = ST_OUT;
                else
                    state_next = ST_PAD;
            end
            ST_OUT:
            begin
                if (dig_ready && (out_idx_reg == MD5_LAST_IDX))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl           = '0;
        ctl.push_src  = SRC_WORD;
        ctl.round_idx = round_reg;
        ctl.fill      = fill_reg;
        ctl.out_idx   = out_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.msg_ready = 1'b1;
                ctl.push_en   = msg_valid;
                ctl.push_src  = last_word ? SRC_FIRST : SRC_WORD;
                ctl.load_work = msg_valid && fill_top;
            end
            ST_PAD:
            begin
                ctl.push_en   = 1'b1;
                ctl.push_src  = pad_src;
                ctl.load_work = fill_top;
            end
            ST_ROUND: ctl.round_en = 1'b1;
            ST_FINAL: ctl.final_en = 1'b1;
            ST_OUT:
            begin
                ctl.out_valid = 1'b1;
                ctl.reinit    = dig_ready && (out_idx_reg == MD5_LAST_IDX);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        fill_next     = ctl.push_en ? fill_reg + 4'd1 : fill_reg;
        round_next    = ctl.round_en ? round_reg + 6'd1 : round_reg;
        out_idx_next  = (ctl.out_valid && dig_ready) ? out_idx_reg + 2'd1 : out_idx_reg;
        pend80_next   = pend80_reg;
        lo_done_next  = lo_done_reg;
        len_done_next = len_done_reg;
        padding_next  = padding_reg;
        if (accept && last_word)
        begin
            pend80_next  = count_full;
            padding_next = 1'b1;
        end
        if (ctl.push_en && (ctl.push_src == SRC_PAD80))
            pend80_next = 1'b0;
        if (ctl.push_en && (ctl.push_src == SRC_LEN_LO))
            lo_done_next = 1'b1;
        if (ctl.push_en && (ctl.push_src == SRC_LEN_HI))
            len_done_next = 1'b1;
        if (ctl.reinit)
        begin
            lo_done_next  = 1'b0;
            len_done_next = 1'b0;
            padding_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            round_reg    <= '0;
            fill_reg     <= '0;
            out_idx_reg  <= '0;
            pend80_reg   <= 1'b0;
            lo_done_reg  <= 1'b0;
            len_done_reg <= 1'b0;
            padding_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            round_reg    <= round_next;
            fill_reg     <= fill_next;
            out_idx_reg  <= out_idx_next;
            pend80_reg   <= pend80_next;
            lo_done_reg  <= lo_done_next;
            len_done_reg <= len_done_next;
            padding_reg  <= padding_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/md5_hash_engine_checker.sv
`default_nettype none

module md5_hash_engine_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               msg_valid,
    input wire logic               msg_ready,
    input wire md5_pkg::md5_in_t   msg,
    input wire logic               dig_valid,
    input wire logic               dig_ready,
    input wire md5_pkg::md5_out_t  dig
);
    import md5_pkg::*;

    // A stalled digest word holds.
    a_dig_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && !dig_ready |=> dig_valid && $stable(dig))
        else $error("digest word changed while stalled");

    // No new request is taken while the digest is being delivered.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid |-> !msg_ready)
        else $error("request taken during digest output");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid |-> (dig.digest_last == (dig.digest_index == MD5_LAST_IDX)))
        else $error("digest_last does not match the final index");

    // The four digest words follow each other in order with no gap.
    a_dig_order: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && dig_ready && !dig.digest_last |=>
            dig_valid && (dig.digest_index == 2'($past(dig.digest_index) + 2'd1)))
        else $error("digest words out of order");

    // The last word of a message always starts padding, so the engine is busy next.
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && msg.last_word |=> !msg_ready)
        else $error("engine ready right after the last word");

endmodule

bind md5_hash_engine md5_hash_engine_checker u_md5_chk (.*);

`default_nettype wire
